[src/fcm_pkg.sv]
// shared types, constants and helpers of the four-voice chiptune mixer
package fcm_pkg;

	localparam int VOICES = 4;
	localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int PROD_W = 14;
	localparam int ACC_W  = 16 + $clog2(VOICES);

	localparam logic [7:0]  WAVE_TRIANGLE = 8'd0;
	localparam logic [7:0]  WAVE_SAW      = 8'd1;
	localparam logic [7:0]  WAVE_PULSE    = 8'd2;
	localparam logic [7:0]  WAVE_NOISE    = 8'd3;

	localparam logic [15:0] PHASE_HALF    = 16'h8000;
	localparam logic [5:0]  VAL_BIAS      = 6'h20;
	localparam logic [5:0]  VAL_HIGH      = 6'd31;
	localparam logic [5:0]  VAL_LOW       = 6'h20;
	localparam logic [7:0]  SAMPLE_BIAS   = 8'd128;

	localparam logic [7:0]  DIVIDER_RESET = 8'd93;
	localparam logic [7:0]  NOISE_A_RESET = 8'd1;
	localparam logic [7:0]  NOISE_B_RESET = 8'd50;
	localparam logic [7:0]  NOISE_C_RESET = 8'd3;
	localparam logic [7:0]  NOISE_X_RESET = 8'd1;

	localparam logic        FUNC_TICK     = 1'b0;
	localparam logic        FUNC_WRITE    = 1'b1;

	localparam int          PADDR_W       = 3;
	localparam logic        REG_FRAME_DIV = 1'b0;

	typedef struct packed {
		logic        func;
		logic [1:0]  voice;
		logic [15:0] freq;
		logic [15:0] duty;
		logic [7:0]  waveform;
		logic [7:0]  volume;
	} in_item_t;

	typedef struct packed {
		logic [7:0] sample;
		logic       frame_tick;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] x;
	} noise_t;

	// one step of the add/xor noise generator
	function automatic noise_t noise_next(input noise_t n);
		noise_t r;
		r.x = n.x + 8'd1;
		r.a = n.a ^ n.c ^ r.x;
		r.b = n.b + r.a;
		r.c = (n.c + {1'b0, r.b[7:1]}) ^ r.a;
		return r;
	endfunction

endpackage

[src/four_voice_chiptune_mixer_top.sv]
// four-voice chiptune mixer: settings store, voice sequencer and shared multiply-accumulate
// a sample tick is taken, its result beat is registered at once from the byte
// held by the previous tick, then one voice is rendered and mixed per cycle
// through the single multiply-accumulate unit
// a settings write is taken whenever the sequencer is idle
// arst_n clears phases, voice settings, frame count and held byte, and seeds the noise
// generator; no clearing pass is needed
module four_voice_chiptune_mixer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  fcm_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output fcm_pkg::out_item_t              out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fcm_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import fcm_pkg::*;

	// voice settings and phases, one entry per voice
	logic [15:0] phase_q [VOICES];
	logic [15:0] freq_q  [VOICES];
	logic [15:0] duty_q  [VOICES];
	logic [7:0]  wave_q  [VOICES];
	logic [7:0]  gain_q  [VOICES];

	noise_t      noise_q;
	logic [7:0]  frame_count_q;
	logic [7:0]  held_q;
	logic [7:0]  divider_q;

	state_t      state_q, state_d;
	logic [VIDX_W-1:0]      vcnt_q;
	logic signed [ACC_W-1:0] acc_q;

	logic        out_valid_q;
	out_item_t   out_q;

	logic        in_accept;
	logic        tick_accept;
	logic        write_accept;
	logic        last_voice;
	logic        run_step;

	// render / mix datapath
	logic [15:0] cur_phase;
	logic [7:0]  cur_wave;
	logic [5:0]  cur_val;
	noise_t      noise_d;
	logic signed [PROD_W-1:0] val_ext;
	logic signed [PROD_W-1:0] gain_ext;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc_d;
	logic signed [ACC_W-1:0]  acc_shift;

	// ---------------------------------------------------------------- handshake
	// a tick may go in while the output beat leaves in the same cycle
	assign in_stall     = (state_q != ST_IDLE) ||
	                      (out_valid_q && out_stall && (in_data.func == FUNC_TICK));
	assign in_accept    = in_valid && !in_stall;
	assign tick_accept  = in_accept && (in_data.func == FUNC_TICK);
	assign write_accept = in_accept && (in_data.func == FUNC_WRITE);
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

	// ---------------------------------------------------------------- sequencer
	assign last_voice = (vcnt_q == VIDX_W'(VOICES - 1));

	always_comb begin
		state_d  = state_q;
		run_step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_accept) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				run_step = 1'b1;
				if (last_voice) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (tick_accept) begin
				vcnt_q <= '0;
			end else if (run_step) begin
				vcnt_q <= vcnt_q + VIDX_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------- render
	// value of the current voice in -32..31, held as six-bit two's complement
	assign cur_phase = phase_q[vcnt_q];
	assign cur_wave  = wave_q[vcnt_q];
	assign noise_d   = noise_next(noise_q);

	always_comb begin
		case (cur_wave)
			WAVE_TRIANGLE: begin
				// rising half counts up from -32, falling half counts down from 31
				if (cur_phase < PHASE_HALF) begin
					cur_val = cur_phase[14:9] ^ VAL_BIAS;
				end else begin
					cur_val = (~cur_phase[14:9]) ^ VAL_BIAS;
				end
			end
			WAVE_SAW:   cur_val = cur_phase[15:10] ^ VAL_BIAS;
			WAVE_PULSE: cur_val = (cur_phase > duty_q[vcnt_q]) ? VAL_LOW : VAL_HIGH;
			WAVE_NOISE: cur_val = noise_d.c[5:0] ^ VAL_BIAS;
			default:    cur_val = '0;
		endcase
	end

	// shared multiply-accumulate: signed value times unsigned gain
	assign val_ext   = PROD_W'($signed(cur_val));
	assign gain_ext  = $signed({{(PROD_W-8){1'b0}}, gain_q[vcnt_q]});
	assign prod      = val_ext * gain_ext;
	assign acc_d     = acc_q + ACC_W'(prod);
	assign acc_shift = acc_d >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			held_q  <= '0;
			noise_q <= '{a: NOISE_A_RESET, b: NOISE_B_RESET, c: NOISE_C_RESET,
			             x: NOISE_X_RESET};
			for (int v = 0; v < VOICES; v++) begin
				phase_q[v] <= '0;
			end
		end else begin
			if (tick_accept) begin
				acc_q <= '0;
			end else if (run_step) begin
				acc_q            <= acc_d;
				phase_q[vcnt_q]  <= cur_phase + freq_q[vcnt_q];
				// generator steps once per noise voice rendered
				if (cur_wave == WAVE_NOISE) begin
					noise_q <= noise_d;
				end
				// mix finished: bias and keep for the next tick
				if (last_voice) begin
					held_q <= acc_shift[7:0] + SAMPLE_BIAS;
				end
			end
		end
	end

	// ---------------------------------------------------------------- voice settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				freq_q[v] <= '0;
				duty_q[v] <= '0;
				wave_q[v] <= '0;
				gain_q[v] <= '0;
			end
		end else if (write_accept && (int'(in_data.voice) < VOICES)) begin
			freq_q[VIDX_W'(in_data.voice)] <= in_data.freq;
			duty_q[VIDX_W'(in_data.voice)] <= in_data.duty;
			wave_q[VIDX_W'(in_data.voice)] <= in_data.waveform;
			gain_q[VIDX_W'(in_data.voice)] <= in_data.volume;
		end
	end

	// ---------------------------------------------------------------- frame strobe and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (tick_accept) begin
				out_valid_q <= 1'b1;
				if (frame_count_q != 8'd0) begin
					frame_count_q <= frame_count_q - 8'd1;
				end else begin
					frame_count_q <= divider_q;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload register, loaded with the byte left by the previous tick
	always_ff @(posedge clk) begin
		if (tick_accept) begin
			out_q.sample     <= held_q;
			out_q.frame_tick <= (frame_count_q == 8'd0);
		end
	end

	// ---------------------------------------------------------------- configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FRAME_DIV) ? {24'd0, divider_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q <= DIVIDER_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_DIV)) begin
			divider_q <= pwdata[7:0];
		end
	end

	// ---------------------------------------------------------------- assertions
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |-> (state_q == ST_IDLE))
		else $error("item accepted while sequencer busy");

	a_tick_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		tick_accept |=> (state_q == ST_RUN) && (vcnt_q == '0) && out_valid_q)
		else $error("tick did not start the voice sweep and output beat");

	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(run_step && last_voice) |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after last voice");

	a_beat_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled output beat dropped");

	a_write_no_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(write_accept && !out_valid_q) |=> !out_valid_q)
		else $error("settings write produced an output beat");

endmodule
